// File: rtl/sbs_pkg.sv
// Shared types and constants for the spectrum bin scaler.
// No dependencies.
package sbs_pkg;
    localparam int MaxBlock    = 4096;
    localparam int SampleWidth = 24;
    localparam int MagFrac     = 32 - SampleWidth;
    localparam logic [11:0] MaxBins = 12'(MaxBlock / 2 + 1);
    localparam logic [31:0] SatPos  = 32'h7FFF_FFFF;
    localparam logic [31:0] DbPerLog2 = 32'd3232284966;

    localparam logic [1:0] ModeAmp  = 2'd0;
    localparam logic [1:0] ModePow  = 2'd1;
    localparam logic [1:0] ModeDen  = 2'd2;
    localparam logic [1:0] ModeDb   = 2'd3;

    localparam logic [2:0] RegMode  = 3'd0;
    localparam logic [2:0] RegBins  = 3'd1;
    localparam logic [2:0] RegAgain = 3'd2;
    localparam logic [2:0] RegDgain = 3'd3;
    localparam logic [2:0] RegFloor = 3'd4;
    localparam logic [2:0] RegReady = 3'd5;

    typedef struct packed {
        logic start;
        logic out_take;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;
endpackage

// File: rtl/sbs_datapath.sv
// Datapath of the spectrum bin scaler: multi-cycle sequencer for sqrt,
// log2 and wide multiplies built on 32x32 multipliers. Uses sbs_pkg.
module sbs_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbs_pkg::t_cmd      i_cmd,
    output sbs_pkg::t_sts      o_sts,
    input  logic signed [23:0] i_re,
    input  logic signed [23:0] i_im,
    input  logic               i_dbl,
    input  logic               i_bad,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_again,
    input  logic [31:0]        i_dgain,
    input  logic [31:0]        i_floor,
    output logic [31:0]        o_value
);
    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001, S_SQ1 = 11'b00000000010, S_SQ2 = 11'b00000000100,
        S_SQRT = 11'b00000001000, S_AMP = 11'b00000010000, S_PW  = 11'b00000100000,
        S_DEN  = 11'b00001000000, S_LGN = 11'b00010000000, S_LGF = 11'b00100000000,
        S_DBM  = 11'b01000000000, S_FIN = 11'b10000000000
    } t_dp;

    t_dp          r_st;
    logic [47:0]  r_s;
    logic [63:0]  r_rem;
    logic [31:0]  r_root;
    logic [5:0]   r_cnt;
    logic [63:0]  r_acc;
    logic [31:0]  r_y;
    logic         r_lsel;
    logic [23:0]  r_lsum;
    logic [23:0]  r_are, r_aim;
    logic [31:0]  r_val;
    logic [1:0]   r_ph;
    logic [63:0]  r_prod;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic [63:0]  rad;
    logic [63:0]  lx;
    logic [5:0]   msb;
    logic [63:0]  ynorm;
    logic [63:0]  ysq;
    logic         neg;
    logic [23:0]  labs;
    logic [55:0]  dbm;
    logic [31:0]  dbr;

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign rad   = {16'd0, r_s} << (2 * sbs_pkg::MagFrac);
    assign lx    = r_lsel ? {32'd0, i_again} : {16'd0, r_s};
    assign ysq   = 64'(r_y) * 64'(r_y) >> 31;
    assign neg   = r_lsum[23];
    assign labs  = neg ? (~r_lsum + 24'd1) : r_lsum;
    assign dbm   = 56'(labs) * 56'(sbs_pkg::DbPerLog2);
    assign dbr   = 32'((dbm + 56'd536870912) >> 30);

    function automatic logic [31:0] sat_den(input logic [64:0] full,
                                            input logic [30:0] hi);
        logic [64:0] r;
        begin
            r = i_dbl ? ((full >> 15) + 65'(full[14])) : ((full >> 16) + 65'(full[15]));
            sat_den = (hi[30:29] != 2'd0 || r > 65'(sbs_pkg::SatPos)) ?
                      sbs_pkg::SatPos : r[31:0];
        end
    endfunction

    always_comb begin
        msb = '0;
        for (int i = 0; i < 64; i++) begin
            if (lx[i]) msb = 6'(i);
        end
        ynorm = (msb >= 6'd31) ? (lx >> (msb - 6'd31)) : (lx << (6'd31 - msb));
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_st)
            S_SQ1:   begin mul_a = 32'(r_are); mul_b = 32'(r_are); end
            S_SQ2:   begin mul_a = 32'(r_aim); mul_b = 32'(r_aim); end
            S_AMP:   begin mul_a = r_root;     mul_b = i_again;    end
            S_PW:    begin mul_a = r_acc[31:0]; mul_b = r_acc[31:0]; end
            S_DEN:   begin
                mul_a = (r_ph == 2'd0) ? r_s[31:0] : 32'(r_s[47:32]);
                mul_b = i_dgain;
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: if (i_cmd.start) begin
                    r_are <= 24'(i_re[23] ? -i_re : i_re);
                    r_aim <= 24'(i_im[23] ? -i_im : i_im);
                    r_st  <= S_SQ1;
                end
                S_SQ1: begin
                    r_s  <= mul_p[47:0];
                    r_st <= S_SQ2;
                end
                S_SQ2: begin
                    r_s    <= r_s + mul_p[47:0];
                    r_cnt  <= 6'd0;
                    r_lsel <= 1'b0;
                    if (i_bad) begin
                        r_val <= '0;
                        r_st  <= S_FIN;
                    end else begin
                        case (i_mode)
                            sbs_pkg::ModeDen: begin r_ph <= 2'd0; r_st <= S_DEN; end
                            sbs_pkg::ModeDb:  r_st <= S_LGN;
                            default: begin
                                r_rem  <= '0;
                                r_root <= '0;
                                r_st   <= S_SQRT;
                            end
                        endcase
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle, restoring
                    if ({r_rem[61:0], rad[63 - 2 * r_cnt -: 2]} >=
                        ({r_root, 2'b00} | 64'd1)) begin
                        r_rem  <= {r_rem[61:0], rad[63 - 2 * r_cnt -: 2]}
                                  - ({r_root, 2'b00} | 64'd1);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[61:0], rad[63 - 2 * r_cnt -: 2]};
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) r_st <= S_AMP;
                end
                S_AMP: begin
                    r_acc <= i_dbl ?
                        64'((mul_p >> (15 + sbs_pkg::MagFrac)) +
                            64'(mul_p[14 + sbs_pkg::MagFrac])) :
                        64'((mul_p >> (16 + sbs_pkg::MagFrac)) +
                            64'(mul_p[15 + sbs_pkg::MagFrac]));
                    r_st <= S_PW;
                end
                S_PW: begin
                    if (i_mode == sbs_pkg::ModeAmp) begin
                        r_val <= (r_acc > 64'(sbs_pkg::SatPos)) ? sbs_pkg::SatPos
                                                                : r_acc[31:0];
                    end else if (r_acc >= 64'h100_0000) begin
                        r_val <= sbs_pkg::SatPos;
                    end else begin
                        r_val <= 32'((mul_p >> 17) + 64'(mul_p[16]));
                    end
                    r_st <= S_FIN;
                end
                S_DEN: begin
                    if (r_ph == 2'd0) begin
                        r_prod <= mul_p;
                        r_ph   <= 2'd1;
                    end else begin
                        // full = hi*2^32 + lo; saturate if the rounded, shifted result exceeds SatPos
                        r_acc <= r_prod;
                        if (mul_p[63:31] != 33'd0) begin
                            r_val <= sbs_pkg::SatPos;
                        end else begin
                            r_val <= sat_den({2'b00, mul_p[30:0], 32'd0} + 65'(r_prod),
                                             mul_p[30:0]);
                        end
                        r_st <= S_FIN;
                    end
                end
                S_LGN: begin
                    if (r_lsel == 1'b0 && r_s == 48'd0) begin
                        r_val <= i_floor;
                        r_st  <= S_FIN;
                    end else begin
                        r_y   <= ynorm[31:0];
                        r_acc <= {58'd0, msb};
                        r_cnt <= 6'd0;
                        r_st  <= S_LGF;
                    end
                end
                S_LGF: begin
                    if (ysq[32]) begin
                        r_y   <= ysq[32:1];
                        r_acc <= {r_acc[62:0], 1'b1};
                    end else begin
                        r_y   <= ysq[31:0];
                        r_acc <= {r_acc[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        if (!r_lsel) begin
                            r_lsum <= 24'(ysq[32] ? {r_acc[62:0], 1'b1}
                                                  : {r_acc[62:0], 1'b0})
                                      + (i_dbl ? 24'h20000 : 24'd0) - 24'h410000;
                            r_lsel <= 1'b1;
                            r_st   <= S_LGN;
                        end else begin
                            r_lsum <= r_lsum + 24'({(ysq[32] ? {r_acc[62:0], 1'b1}
                                                   : {r_acc[62:0], 1'b0}), 1'b0});
                            r_st   <= S_DBM;
                        end
                    end
                end
                S_DBM: begin
                    if (neg) begin
                        r_val <= ($signed(-dbr) < $signed(i_floor)) ? i_floor : -dbr;
                    end else begin
                        r_val <= ($signed(dbr) < $signed(i_floor)) ? i_floor : dbr;
                    end
                    r_st <= S_FIN;
                end
                S_FIN: if (i_cmd.out_take) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_sts.done = (r_st == S_FIN);
    assign o_value    = r_val;
endmodule

// File: rtl/sbs_ctrl.sv
// Controller of the spectrum bin scaler: handshakes, configuration,
// bin position tracking. Uses sbs_pkg.
module sbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic          i_last,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  sbs_pkg::t_sts i_sts,
    output sbs_pkg::t_cmd o_cmd,
    output logic          o_dbl,
    output logic          o_bad,
    output logic          o_lastv,
    output logic [1:0]    o_mode,
    output logic [31:0]   o_again,
    output logic [31:0]   o_dgain,
    output logic [31:0]   o_floor
);
    typedef enum logic [2:0] {
        C_IDLE = 3'b001, C_BUSY = 3'b010, C_OUT = 3'b100
    } t_cst;

    t_cst        r_st, n_st;
    logic [11:0] r_pos, r_bins;
    logic [1:0]  r_mode;
    logic [31:0] r_again, r_dgain, r_floor;
    logic        r_ready, r_dbl, r_bad, r_lastv;
    logic        fend, acc;

    assign acc  = i_s_tvalid && o_s_tready;
    assign fend = (r_bins == 12'd0) || (13'(r_pos) + 13'd1 >= 13'(r_bins));

    always_comb begin
        n_st = r_st;
        case (r_st)
            C_IDLE:  if (acc) n_st = C_BUSY;
            C_BUSY:  if (i_sts.done) n_st = C_OUT;
            C_OUT:   if (i_m_tready) n_st = C_IDLE;
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= C_IDLE;
            r_pos   <= '0;
            r_mode  <= sbs_pkg::ModeAmp;
            r_bins  <= 12'd2049;
            r_again <= '0;
            r_dgain <= '0;
            r_floor <= 32'hFF88_0000;
            r_ready <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sbs_pkg::RegMode:  r_mode  <= i_cfg_data[1:0];
                    sbs_pkg::RegBins:  r_bins  <= i_cfg_data[11:0];
                    sbs_pkg::RegAgain: r_again <= i_cfg_data;
                    sbs_pkg::RegDgain: r_dgain <= i_cfg_data;
                    sbs_pkg::RegFloor: r_floor <= i_cfg_data;
                    sbs_pkg::RegReady: r_ready <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (acc) begin
                r_pos   <= (fend || i_last) ? 12'd0 : r_pos + 12'd1;
                r_dbl   <= (r_pos != 12'd0) && !fend;
                r_lastv <= i_last;
                r_bad   <= !r_ready || r_again == 32'd0 || r_bins == 12'd0 ||
                           r_bins > sbs_pkg::MaxBins ||
                           (r_mode == sbs_pkg::ModeDen && r_dgain == 32'd0);
            end
        end
    end

    assign o_s_tready   = (r_st == C_IDLE);
    assign o_m_tvalid   = (r_st == C_OUT);
    assign o_cmd.start    = acc;
    assign o_cmd.out_take = (r_st == C_OUT) && i_m_tready;
    assign o_dbl   = r_dbl;
    assign o_bad   = r_bad;
    assign o_lastv = r_lastv;
    assign o_mode  = r_mode;
    assign o_again = r_again;
    assign o_dgain = r_dgain;
    assign o_floor = r_floor;
endmodule

// File: rtl/spectrum_bin_scaler_core.sv
// Input transaction to output valid: a refused set-up passes S_SQ1, S_SQ2, S_FIN;
// density adds two S_DEN phases; amplitude/power a 32-step sqrt, S_AMP and S_PW;
// decibel two 16-step log2 and S_DBM; an empty bin in dB goes from S_LGN to S_FIN.
// One bin at a time: next bin accepted the cycle after the output transaction.
// Reset (synchronous, i_rst_n low) clears bin position and loads register
// defaults: mode amplitude, 2049 bins, gains 0, floor -120 dB, not ready.
module spectrum_bin_scaler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // bin_real[23:0], bin_imag[47:24]
    input  logic        s_axis_tlast,   // last_bin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value[31:0], status[32], zero pad
    output logic        m_axis_tlast,   // last_value
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    sbs_pkg::t_cmd cmd;
    sbs_pkg::t_sts sts;
    logic        dbl, bad, lastv;
    logic [1:0]  mode;
    logic [31:0] again, dgain, flr, val;

    sbs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .o_s_tready(s_axis_tready), .i_last(s_axis_tlast),
        .o_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_sts(sts), .o_cmd(cmd), .o_dbl(dbl), .o_bad(bad), .o_lastv(lastv),
        .o_mode(mode), .o_again(again), .o_dgain(dgain), .o_floor(flr)
    );

    sbs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_re(s_axis_tdata[23:0]), .i_im(s_axis_tdata[47:24]),
        .i_dbl(dbl), .i_bad(bad), .i_mode(mode), .i_again(again),
        .i_dgain(dgain), .i_floor(flr), .o_value(val)
    );

    assign m_axis_tdata = {7'd0, bad, val};
    assign m_axis_tlast = lastv;
endmodule

// File: dv/tb_spectrum_bin_scaler_core.sv
// Testbench for spectrum_bin_scaler_core: directed and random STFT bins under
// several register settings, each result checked against an in-bench predictor or a directed expected value.
// Depends on rtl/sbs_pkg.sv and rtl/spectrum_bin_scaler_core.sv.
module tb_spectrum_bin_scaler_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
        logic        last;
    } t_scaled;

    typedef struct {
        logic [23:0] re;
        logic [23:0] im;
        logic        last;
        logic        has_exp;
        logic [31:0] exp_value;
        logic        exp_status;
    } t_bin_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    spectrum_bin_scaler_core dut (.*);

    logic [1:0]  p_mode;
    logic [11:0] p_bins;
    logic [31:0] p_again;
    logic [31:0] p_dgain;
    logic [31:0] p_floor;
    logic        p_ready;
    logic [11:0] p_pos;

    t_scaled     scaled_q[$];
    int          mismatches;
    int          fails;
    int          rdy_idle;
    bit          quiet;
    bit          hold_long;
    longint      cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] sqrt_floor(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint log2_q16(logic [63:0] x);
        int n;
        logic [127:0] y;
        logic [63:0] frac;
        n = 63;
        frac = 0;
        while (n > 0 && !x[n]) n--;
        y = (n >= 31) ? 128'(x >> (n - 31)) : 128'(x << (31 - n));
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 128'h1_0000_0000) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'((64'(n) << 16) | frac);
    endfunction

    function automatic logic [63:0] round_shift(logic [63:0] p, int sh);
        return (p >> sh) + 64'((p >> (sh - 1)) & 64'd1);
    endfunction

    function automatic logic [31:0] clip_pos(logic [63:0] v);
        return (v > 64'(sbs_pkg::SatPos)) ? sbs_pkg::SatPos : v[31:0];
    endfunction

    function automatic t_scaled scale_bin(logic [23:0] re_b, logic [23:0] im_b, logic last);
        longint re, im, fl, l, r, val;
        logic [63:0] s, mag, amp, m;
        logic [127:0] wide;
        logic fend, dbl, bad;
        t_scaled o;
        re = longint'($signed(re_b));
        im = longint'($signed(im_b));
        s = 64'(re * re) + 64'(im * im);
        fend = (p_bins == 0) || (13'(p_pos) + 13'd1 >= 13'(p_bins));
        dbl = (p_pos != 0) && !fend;
        bad = !p_ready || p_again == 0 || p_bins == 0 || p_bins > sbs_pkg::MaxBins ||
              (p_mode == sbs_pkg::ModeDen && p_dgain == 0);
        p_pos = (fend || last) ? 12'd0 : p_pos + 12'd1;
        val = 0;
        if (!bad) begin
            case (p_mode)
                sbs_pkg::ModeAmp, sbs_pkg::ModePow: begin
                    mag = sqrt_floor(s << (2 * sbs_pkg::MagFrac));
                    amp = round_shift(mag * 64'(p_again),
                                      16 + sbs_pkg::MagFrac - (dbl ? 1 : 0));
                    if (p_mode == sbs_pkg::ModeAmp) val = longint'(clip_pos(amp));
                    else if (amp >= 64'h100_0000) val = longint'(sbs_pkg::SatPos);
                    else val = longint'(clip_pos(round_shift(amp * amp, 17)));
                end
                sbs_pkg::ModeDen: begin
                    wide = 128'(s) * 128'(p_dgain);
                    if (wide[127:64] != 0) val = longint'(sbs_pkg::SatPos);
                    else val = longint'(clip_pos(round_shift(wide[63:0], dbl ? 15 : 16)));
                end
                default: begin
                    fl = longint'($signed(p_floor));
                    if (s == 0) begin
                        val = fl;
                    end else begin
                        l = log2_q16(s) + 2 * log2_q16(64'(p_again)) +
                            (dbl ? (64'sd2 << 16) : 0) - (64'sd65 << 16);
                        m = 64'(l < 0 ? -l : l) * 64'(sbs_pkg::DbPerLog2);
                        r = longint'((m + (64'd1 << 29)) >> 30);
                        val = l < 0 ? -r : r;
                        if (val < fl) val = fl;
                    end
                end
            endcase
        end
        o.value = val[31:0];
        o.status = bad;
        o.last = last;
        return o;
    endfunction

    // register write, predictor copy updated alongside
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sbs_pkg::RegMode:  p_mode = data[1:0];
            sbs_pkg::RegBins:  p_bins = data[11:0];
            sbs_pkg::RegAgain: p_again = data;
            sbs_pkg::RegDgain: p_dgain = data;
            sbs_pkg::RegFloor: p_floor = data;
            sbs_pkg::RegReady: p_ready = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (scaled_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_bin(logic [23:0] re, logic [23:0] im, logic last,
                            logic has_exp = 1'b0, logic [31:0] exp_value = '0,
                            logic exp_status = 1'b0);
        t_scaled pred;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {im, re};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = scale_bin(re, im, last);
        if (has_exp) begin
            pred.value = exp_value;
            pred.status = exp_status;
        end
        scaled_q.push_back(pred);
    endtask

    task automatic send_random_bin();
        logic [23:0] re, im;
        case ($urandom_range(0, 5))
            0: re = 24'h800000;
            1: re = 24'h7FFFFF;
            2: re = 24'($urandom_range(0, 15));
            default: re = 24'($urandom);
        endcase
        im = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(0, 3)) : 24'($urandom);
        send_bin(re, im, $urandom_range(0, 40) == 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rdy_idle <= 0;
        end else if (hold_long) begin
            m_axis_tready <= 1'b0;
        end else if (rdy_idle != 0) begin
            m_axis_tready <= 1'b0;
            rdy_idle <= rdy_idle - 1;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            m_axis_tready <= 1'b0;
            rdy_idle <= $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_scaled got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata[31:0];
            got.status = m_axis_tdata[32];
            got.last = m_axis_tlast;
            if (scaled_q.size() == 0) begin
                fails++;
                if (mismatches++ < 10) $display("unexpected transaction %h", got);
            end else begin
                want = scaled_q.pop_front();
                if (got !== want) begin
                    fails++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp value %h status %b last %b, got %h %b %b",
                                 want.value, want.status, want.last,
                                 got.value, got.status, got.last);
                end
            end
        end
    end

    initial begin
        t_bin_row rows[$];
        logic [31:0] floors[3];
        int hold_cnt;
        fails = 0;
        mismatches = 0;
        quiet = 0;
        hold_long = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        p_mode = sbs_pkg::ModeAmp;
        p_bins = 12'd2049;
        p_again = 0;
        p_dgain = 0;
        p_floor = 32'hFF88_0000;
        p_ready = 0;
        p_pos = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: not ready, refused
        rows.push_back('{24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 32'd0, 1'b1});
        rows.push_back('{24'd0, 24'd0, 1'b1, 1'b1, 32'd0, 1'b1});
        foreach (rows[i]) send_bin(rows[i].re, rows[i].im, rows[i].last,
                                   rows[i].has_exp, rows[i].exp_value, rows[i].exp_status);
        drain();

        write_reg(sbs_pkg::RegReady, 32'd1);
        write_reg(sbs_pkg::RegAgain, 32'hFFFF_FFFF);
        write_reg(sbs_pkg::RegBins, 32'd4);
        write_reg(sbs_pkg::RegDgain, 32'd0);
        floors = '{32'hFF88_0000, 32'h8000_0000, 32'h0};
        for (int md = 0; md < 4; md++) begin
            write_reg(sbs_pkg::RegMode, 32'(md));
            foreach (floors[k]) begin
                write_reg(sbs_pkg::RegFloor, floors[k]);
                send_bin(24'h7FFFFF, 24'h7FFFFF, 1'b0);
                send_bin(24'h800000, 24'h800000, 1'b0);
                send_bin(24'd0, 24'd0, 1'b0);
                send_bin(24'd1, 24'hFFFFFF, 1'b0);
                send_bin(24'd3, 24'd0, 1'b1);
                drain();
            end
            write_reg(sbs_pkg::RegDgain, 32'hFFFF_FFFF);
        end

        // refused settings: oversized frame, zero frame, zero gain
        write_reg(sbs_pkg::RegBins, 32'd2050);
        send_bin(24'd5, 24'd5, 1'b0);
        drain();
        write_reg(sbs_pkg::RegBins, 32'd0);
        send_bin(24'd5, 24'd5, 1'b0);
        drain();
        write_reg(sbs_pkg::RegBins, 32'd1);
        write_reg(sbs_pkg::RegAgain, 32'd0);
        send_bin(24'd5, 24'd5, 1'b0);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(sbs_pkg::RegMode, 32'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: write_reg(sbs_pkg::RegBins, 32'd2049);
                1: write_reg(sbs_pkg::RegBins, 32'd1);
                default: write_reg(sbs_pkg::RegBins, 32'($urandom_range(2, 9)));
            endcase
            write_reg(sbs_pkg::RegAgain, ($urandom_range(0, 9) == 0) ? 32'd0 :
                      ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(1, 70000))));
            write_reg(sbs_pkg::RegDgain, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom);
            write_reg(sbs_pkg::RegFloor, $urandom_range(0, 1) ? 32'hFF88_0000 :
                      -32'($urandom_range(0, 1 << 30)));
            write_reg(sbs_pkg::RegReady, 32'($urandom_range(0, 12) != 0));
            quiet = (ph >= 10);
            if (ph == 3) begin
                fork
                    begin
                        hold_long = 1;
                        hold_cnt = 0;
                        while (hold_cnt < 400) begin
                            @(posedge i_clk);
                            hold_cnt++;
                        end
                        hold_long = 0;
                    end
                join_none
            end
            // each bins write in random flow shrinks/grows frame mid-position too
            for (int n = 0; n < 135; n++) send_random_bin();
            drain();
        end

        drain();
        if (fails == 0 && scaled_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: spectrum_bin_scaler_core.f
rtl/sbs_pkg.sv
rtl/sbs_datapath.sv
rtl/sbs_ctrl.sv
rtl/spectrum_bin_scaler_core.sv
dv/tb_spectrum_bin_scaler_core.sv
